// ----- rtl/u8v_pkg.sv -----
// ----------------------------------------------------------------------------
// u8v_pkg
// Shared types and constants of the UTF-8 string validator.
// ----------------------------------------------------------------------------
package u8v_pkg;

   // Byte classes.
   localparam logic [7:0] BYTE_NUL       = 8'h00;
   localparam logic [7:0] BYTE_ASCII_MAX = 8'h7f;
   localparam logic [7:0] LEAD2_MIN      = 8'hc2;
   localparam logic [7:0] LEAD2_MAX      = 8'hdf;
   localparam logic [7:0] LEAD3_MIN      = 8'he0;
   localparam logic [7:0] LEAD3_MAX      = 8'hef;
   localparam logic [7:0] LEAD4_MIN      = 8'hf0;
   localparam logic [7:0] LEAD4_MAX      = 8'hf4;
   localparam logic [7:0] CONT_MASK      = 8'hc0;
   localparam logic [7:0] CONT_MARK      = 8'h80;

   // Code point limits.
   localparam int unsigned CP_WIDTH = 21;
   localparam logic [CP_WIDTH-1:0] CP_MIN_LEN1  = 21'h000080;
   localparam logic [CP_WIDTH-1:0] CP_MIN_LEN2  = 21'h000800;
   localparam logic [CP_WIDTH-1:0] CP_MIN_LEN3  = 21'h010000;
   localparam logic [CP_WIDTH-1:0] CP_SURR_LO   = 21'h00d800;
   localparam logic [CP_WIDTH-1:0] CP_SURR_HI   = 21'h00dfff;
   localparam logic [CP_WIDTH-1:0] CP_MAX       = 21'h10ffff;

   // Number of continuation bytes a lead opens.
   localparam logic [1:0] LEN_NONE = 2'd0;
   localparam logic [1:0] LEN_ONE  = 2'd1;
   localparam logic [1:0] LEN_TWO  = 2'd2;
   localparam logic [1:0] LEN_THREE = 2'd3;

   // Default depth of the queue between front and back.
   localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

   // A classified beat: both readings of the byte, as lead and as continuation.
   typedef struct packed {
      logic       last;
      logic       present;
      logic       is_nul;
      logic       lead_bad;
      logic [1:0] lead_len;
      logic [4:0] lead_bits;
      logic       cont_ok;
      logic [5:0] cont_bits;
   } item_type;

endpackage

// ----- rtl/u8v_front.sv -----
// ----------------------------------------------------------------------------
// u8v_front
// Accepts input beats and registers their byte classification.
// ----------------------------------------------------------------------------
module u8v_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_byte_value,
   input  logic              req_byte_present,
   input  logic              req_last_byte,
   output logic              out_valid,
   input  logic              out_ready,
   output u8v_pkg::item_type out_item
);
   import u8v_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;
   item_type item_in;

   // Classify the byte both as a lead and as a continuation.
   always_comb begin
      item_in           = '0;
      item_in.last      = req_last_byte;
      item_in.present   = req_byte_present;
      item_in.is_nul    = (req_byte_value == BYTE_NUL);
      item_in.cont_ok   = ((req_byte_value & CONT_MASK) == CONT_MARK);
      item_in.cont_bits = req_byte_value[5:0];
      item_in.lead_len  = LEN_NONE;
      item_in.lead_bad  = 1'b0;
      item_in.lead_bits = 5'd0;
      if (req_byte_value <= BYTE_ASCII_MAX) begin
         item_in.lead_len = LEN_NONE;
      end else if (req_byte_value >= LEAD2_MIN && req_byte_value <= LEAD2_MAX) begin
         item_in.lead_len  = LEN_ONE;
         item_in.lead_bits = req_byte_value[4:0];
      end else if (req_byte_value >= LEAD3_MIN && req_byte_value <= LEAD3_MAX) begin
         item_in.lead_len  = LEN_TWO;
         item_in.lead_bits = {1'b0, req_byte_value[3:0]};
      end else if (req_byte_value >= LEAD4_MIN && req_byte_value <= LEAD4_MAX) begin
         item_in.lead_len  = LEN_THREE;
         item_in.lead_bits = {2'b00, req_byte_value[2:0]};
      end else begin
         item_in.lead_bad = 1'b1;
      end
   end

   // The stage takes a new beat whenever its current one moves on.
   assign req_ready = !valid_ff || out_ready;
   assign valid_in  = (req_valid && req_ready) || (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

// ----- rtl/u8v_queue.sv -----
// ----------------------------------------------------------------------------
// u8v_queue
// Small FIFO of classified beats between the front and the back.
// ----------------------------------------------------------------------------
module u8v_queue #(
   parameter int unsigned Depth = u8v_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  u8v_pkg::item_type push_item,
   output logic              pop_valid,
   input  logic              pop_ready,
   output u8v_pkg::item_type pop_item
);
   import u8v_pkg::*;

   localparam int unsigned PtrWidth   = $clog2(Depth);
   localparam int unsigned CountWidth = $clog2(Depth + 1);
   localparam logic [PtrWidth-1:0]   PtrLast   = PtrWidth'(Depth - 1);
   localparam logic [CountWidth-1:0] CountFull = CountWidth'(Depth);

   item_type               entry_ff [Depth];
   logic [PtrWidth-1:0]    wr_ptr_ff;
   logic [PtrWidth-1:0]    wr_ptr_in;
   logic [PtrWidth-1:0]    rd_ptr_ff;
   logic [PtrWidth-1:0]    rd_ptr_in;
   logic [CountWidth-1:0]  count_ff;
   logic [CountWidth-1:0]  count_in;
   logic                   push;
   logic                   pop;

   assign push_ready = (count_ff != CountFull);
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_item   = entry_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- rtl/u8v_back.sv -----
// ----------------------------------------------------------------------------
// u8v_back
// Runs the UTF-8 sequence state and holds the per-string result.
// ----------------------------------------------------------------------------
module u8v_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  u8v_pkg::item_type in_item,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_string_valid
);
   import u8v_pkg::*;

   logic [1:0]          cont_left_ff;
   logic [1:0]          cont_left_in;
   logic [1:0]          seq_len_ff;
   logic [1:0]          seq_len_in;
   logic [CP_WIDTH-1:0] code_acc_ff;
   logic [CP_WIDTH-1:0] code_acc_in;
   logic                error_ff;
   logic                error_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic                result_ff;
   logic                result_in;
   logic                take;
   logic                out_free;

   // Non-last beats always move; a last beat needs a free output register.
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign in_ready = !in_item.last || out_free;
   assign take     = in_valid && in_ready;

   // Sequence state update for one beat.
   always_comb begin
      cont_left_in = cont_left_ff;
      seq_len_in   = seq_len_ff;
      code_acc_in  = code_acc_ff;
      error_in     = error_ff;
      if (in_item.present) begin
         if (in_item.is_nul) begin
            error_in = 1'b1;
         end
         if (cont_left_ff == LEN_NONE) begin
            if (in_item.lead_bad) begin
               error_in = 1'b1;
            end else if (in_item.lead_len != LEN_NONE) begin
               code_acc_in  = {{(CP_WIDTH - 5){1'b0}}, in_item.lead_bits};
               seq_len_in   = in_item.lead_len;
               cont_left_in = in_item.lead_len;
            end
         end else begin
            if (!in_item.cont_ok) begin
               error_in = 1'b1;
            end
            code_acc_in  = {code_acc_ff[CP_WIDTH-7:0], in_item.cont_bits};
            cont_left_in = cont_left_ff - 2'd1;
            // Sequence complete: reject overlong, surrogate and out of range.
            if (cont_left_in == LEN_NONE) begin
               if ((seq_len_ff == LEN_ONE && code_acc_in < CP_MIN_LEN1) ||
                   (seq_len_ff == LEN_TWO && code_acc_in < CP_MIN_LEN2) ||
                   (seq_len_ff == LEN_THREE && code_acc_in < CP_MIN_LEN3) ||
                   (code_acc_in >= CP_SURR_LO && code_acc_in <= CP_SURR_HI) ||
                   (code_acc_in > CP_MAX)) begin
                  error_in = 1'b1;
               end
            end
         end
      end
      result_in = in_item.present && !error_in && (cont_left_in == LEN_NONE);
   end

   // State registers; the string state clears on its last beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         cont_left_ff <= LEN_NONE;
         seq_len_ff   <= LEN_NONE;
         code_acc_ff  <= '0;
         error_ff     <= 1'b0;
      end else if (take) begin
         if (in_item.last) begin
            cont_left_ff <= LEN_NONE;
            seq_len_ff   <= LEN_NONE;
            code_acc_ff  <= '0;
            error_ff     <= 1'b0;
         end else begin
            cont_left_ff <= cont_left_in;
            seq_len_ff   <= seq_len_in;
            code_acc_ff  <= code_acc_in;
            error_ff     <= error_in;
         end
      end
   end

   // Output register.
   assign rsp_valid_in = (take && in_item.last) || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && in_item.last) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_string_valid = result_ff;

endmodule

// ----- rtl/utf8_string_validator_core.sv -----
// ----------------------------------------------------------------------------
// utf8_string_validator_core
// Strict UTF-8 checker for a byte string, one byte per beat.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle, sustained, when the result side is ready.
// Path of a last beat: the front classify register, a queue entry, then the back
// state update into the output register, which shows its result.
// The queue between front and back lets either side stall on its own.
// Reset: synchronous, active high; clears all control and sequence state.
module utf8_string_validator_core #(
   parameter int unsigned QueueDepth = u8v_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_byte_value,
   input  logic       req_byte_present,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_string_valid
);
   import u8v_pkg::*;

   logic     front_valid;
   logic     front_ready;
   item_type front_item;
   logic     back_valid;
   logic     back_ready;
   item_type back_item;

   // Front: accept and classify.
   u8v_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_byte_value   (req_byte_value),
      .req_byte_present (req_byte_present),
      .req_last_byte    (req_last_byte),
      .out_valid        (front_valid),
      .out_ready        (front_ready),
      .out_item         (front_item)
   );

   // Decoupling queue.
   u8v_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_item  (front_item),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_item   (back_item)
   );

   // Back: sequence state and result.
   u8v_back u_back (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (back_valid),
      .in_ready         (back_ready),
      .in_item          (back_item),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_string_valid (rsp_string_valid)
   );

endmodule

// ----- rtl/u8v_checker.sv -----
// ----------------------------------------------------------------------------
// u8v_checker
// Port-level checks of the validator, bound to the top level.
// ----------------------------------------------------------------------------
module u8v_checker #(
   parameter int unsigned QueueDepth = u8v_pkg::QUEUE_DEPTH_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       req_last_byte,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_string_valid
);
   import u8v_pkg::*;

   // Strings may sit in the front register, the queue and the output register.
   localparam int unsigned PendMax   = QueueDepth + 2;
   localparam int unsigned PendWidth = $clog2(PendMax + 2);

   logic [PendWidth-1:0] pending_ff;
   logic [PendWidth-1:0] pending_in;
   logic                 last_in;
   logic                 rsp_out;

   assign last_in = req_valid && req_ready && req_last_byte;
   assign rsp_out = rsp_valid && rsp_ready;

   // Count strings whose result has not yet been taken.
   always_comb begin
      pending_in = pending_ff;
      if (last_in && !rsp_out) begin
         pending_in = pending_ff + 1'b1;
      end else if (rsp_out && !last_in) begin
         pending_in = pending_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // A stalled result holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_string_valid))
      else $error("result changed while stalled");

   // No result appears without an outstanding string.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != '0)
      else $error("result without a last beat");

   // Outstanding strings stay within the buffering of the design.
   a_bounded: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= PendWidth'(PendMax))
      else $error("too many strings in flight");

   // Reset leaves no result showing.
   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind utf8_string_validator_core u8v_checker #(
   .QueueDepth (QueueDepth)
) u_u8v_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .req_last_byte    (req_last_byte),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_string_valid (rsp_string_valid)
);

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the strict UTF-8 string validator.
// A short table of hand-picked strings comes first: the empty string, NUL,
// bad leads, overlong forms, surrogates, the largest code point, cut-off and
// broken sequences. Random strings follow, mostly well-formed UTF-8 with
// random code points and some noise, with random idle bursts on both sides,
// one long receiver hold-off and quiet stretches. Every verdict is checked
// against the bench's cycle-free tracker model, or the verdict typed in the table.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import u8v_pkg::*;

   localparam int unsigned RANDOM_BEATS    = 1750;
   localparam int unsigned HOLDOFF_AT      = 500;
   localparam int unsigned DRAIN_AT        = 1100;
   localparam int unsigned QUIET_TAIL_AT   = 1550;
   localparam int unsigned HOLDOFF_CYCLES  = 400;
   localparam int unsigned CYCLE_LIMIT     = 400_000;
   localparam int unsigned DIRECTED_ROWS   = 26;

   // One row of the directed table. The verdict is typed in only where typed is set.
   typedef struct packed {
      logic [7:0] value;
      logic       present;
      logic       last;
      logic       typed;
      logic       verdict;
   } dir_row_type;

   // One input beat as the sender offers it, with its pacing flags.
   typedef struct {
      logic [7:0] value;
      logic       present;
      logic       last;
      bit         typed;
      bit         typed_verdict;
      bit         idling;
      bit         drain_first;
      bit         rx_holdoff;
   } beat_type;

   localparam dir_row_type DIRECTED [DIRECTED_ROWS] = '{
      // Empty string.
      {8'h00, 1'b0, 1'b1, 1'b1, 1'b0},
      // Largest ASCII byte alone.
      {8'h7f, 1'b1, 1'b1, 1'b1, 1'b1},
      // NUL byte.
      {8'h00, 1'b1, 1'b1, 1'b1, 1'b0},
      // Bad lead, largest byte value.
      {8'hff, 1'b1, 1'b1, 1'b1, 1'b0},
      // Overlong three-byte form of U+07FF.
      {8'he0, 1'b1, 1'b0, 1'b0, 1'b0},
      {8'h9f, 1'b1, 1'b0, 1'b0, 1'b0},
      {8'hbf, 1'b1, 1'b1, 1'b1, 1'b0},
      // Surrogate U+D800.
      {8'hed, 1'b1, 1'b0, 1'b0, 1'b0},
      {8'ha0, 1'b1, 1'b0, 1'b0, 1'b0},
      {8'h80, 1'b1, 1'b1, 1'b1, 1'b0},
      // Code point just above U+10FFFF.
      {8'hf4, 1'b1, 1'b0, 1'b0, 1'b0},
      {8'h90, 1'b1, 1'b0, 1'b0, 1'b0},
      {8'h80, 1'b1, 1'b0, 1'b0, 1'b0},
      {8'h80, 1'b1, 1'b1, 1'b1, 1'b0},
      // U+10FFFF, the largest valid code point.
      {8'hf4, 1'b1, 1'b0, 1'b0, 1'b0},
      {8'h8f, 1'b1, 1'b0, 1'b0, 1'b0},
      {8'hbf, 1'b1, 1'b0, 1'b0, 1'b0},
      {8'hbf, 1'b1, 1'b1, 1'b1, 1'b1},
      // Sequence cut short by the end of the string.
      {8'hc2, 1'b1, 1'b1, 1'b1, 1'b0},
      // Continuation that is not of the form 10xxxxxx.
      {8'hc2, 1'b1, 1'b0, 1'b0, 1'b0},
      {8'h41, 1'b1, 1'b1, 1'b1, 1'b0},
      // Bytes followed by an empty terminator.
      {8'h41, 1'b1, 1'b0, 1'b0, 1'b0},
      {8'h00, 1'b0, 1'b1, 1'b1, 1'b0},
      // A byteless beat inside a string is ignored.
      {8'h41, 1'b1, 1'b0, 1'b0, 1'b0},
      {8'h5a, 1'b0, 1'b0, 1'b0, 1'b0},
      {8'h42, 1'b1, 1'b1, 1'b0, 1'b0}
   };

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_byte_value;
   logic       req_byte_present;
   logic       req_last_byte;
   logic       rsp_valid;
   logic       rsp_ready;
   logic       rsp_string_valid;

   beat_type    byte_beats[$];
   logic [7:0]  str_bytes[$];
   bit          expected_verdicts[$];
   int unsigned accept_idx;
   int unsigned failures;
   int unsigned verdicts_checked;
   int unsigned valid_verdicts;
   int unsigned cycle_count;
   int unsigned holdoffs_asked;
   int unsigned holdoffs_done;
   bit          rsp_idling;

   // Generator bookkeeping.
   int unsigned random_items;
   int unsigned strings_built;
   int unsigned quiet_until;
   bit          cur_idling;
   bit          pend_drain;
   bit          pend_holdoff;

   // Tracker state of the bench's own model.
   logic [1:0]  trk_cont_left;
   logic [1:0]  trk_seq_len;
   logic [20:0] trk_acc;
   logic        trk_error;

   utf8_string_validator_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_byte_value   (req_byte_value),
      .req_byte_present (req_byte_present),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_string_valid (rsp_string_valid)
   );

   // Clock with a 20 ns period.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Advances the tracker by one beat; a verdict comes out on the last beat only.
   task automatic step_utf8_tracker(input logic [7:0] b, input logic present,
                                    input logic last, output bit has_verdict,
                                    output bit verdict);
      logic [20:0] cp;
      has_verdict = 1'b0;
      verdict = 1'b0;
      if (present) begin
         if (b == BYTE_NUL) trk_error = 1'b1;
         if (trk_cont_left == LEN_NONE) begin
            // The byte opens a new character.
            if (b <= BYTE_ASCII_MAX) begin
            end else if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
               trk_acc = 21'(b[4:0]);
               trk_seq_len = LEN_ONE;
               trk_cont_left = LEN_ONE;
            end else if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
               trk_acc = 21'(b[3:0]);
               trk_seq_len = LEN_TWO;
               trk_cont_left = LEN_TWO;
            end else if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
               trk_acc = 21'(b[2:0]);
               trk_seq_len = LEN_THREE;
               trk_cont_left = LEN_THREE;
            end else begin
               trk_error = 1'b1;
            end
         end else begin
            // A bad continuation still counts toward the sequence.
            if ((b & CONT_MASK) != CONT_MARK) trk_error = 1'b1;
            trk_acc = {trk_acc[14:0], b[5:0]};
            trk_cont_left = trk_cont_left - 2'd1;
            if (trk_cont_left == LEN_NONE) begin
               cp = trk_acc;
               if ((trk_seq_len == LEN_ONE && cp < CP_MIN_LEN1) ||
                   (trk_seq_len == LEN_TWO && cp < CP_MIN_LEN2) ||
                   (trk_seq_len == LEN_THREE && cp < CP_MIN_LEN3) ||
                   (cp >= CP_SURR_LO && cp <= CP_SURR_HI) ||
                   cp > CP_MAX) begin
                  trk_error = 1'b1;
               end
            end
         end
      end
      if (last) begin
         has_verdict = 1'b1;
         verdict = present && !trk_error && trk_cont_left == LEN_NONE;
         trk_cont_left = LEN_NONE;
         trk_seq_len = LEN_NONE;
         trk_acc = '0;
         trk_error = 1'b0;
      end
   endtask

   task automatic note_failure(input string what, input logic exp_v, input logic act_v);
      failures++;
      if (failures <= 10) begin
         $display("MISMATCH %s: expected %b, got %b (cycle %0d)", what, exp_v, act_v,
                  cycle_count);
      end
   endtask

   // Queues one beat with the pacing flags that are pending for it.
   task automatic add_beat(input logic [7:0] value, input logic present, input logic last,
                           input bit typed, input bit typed_verdict);
      beat_type beat;
      beat.value = value;
      beat.present = present;
      beat.last = last;
      beat.typed = typed;
      beat.typed_verdict = typed_verdict;
      beat.idling = cur_idling;
      beat.drain_first = pend_drain;
      beat.rx_holdoff = pend_holdoff;
      pend_drain = 1'b0;
      pend_holdoff = 1'b0;
      byte_beats.push_back(beat);
   endtask

   function automatic int unsigned natural_len(input int unsigned cp);
      if (cp < 'h80) return 1;
      if (cp < 'h800) return 2;
      if (cp < 'h10000) return 3;
      return 4;
   endfunction

   // Encodes a code point into a byte sequence of the given length; a longer
   // length than needed gives an overlong form.
   task automatic append_seq(input int unsigned cp, input int unsigned len);
      case (len)
         1: str_bytes.push_back(8'(cp & 'h7f));
         2: begin
            str_bytes.push_back(8'hc0 | 8'((cp >> 6) & 'h1f));
            str_bytes.push_back(8'h80 | 8'(cp & 'h3f));
         end
         3: begin
            str_bytes.push_back(8'he0 | 8'((cp >> 12) & 'h0f));
            str_bytes.push_back(8'h80 | 8'((cp >> 6) & 'h3f));
            str_bytes.push_back(8'h80 | 8'(cp & 'h3f));
         end
         default: begin
            str_bytes.push_back(8'hf0 | 8'((cp >> 18) & 'h07));
            str_bytes.push_back(8'h80 | 8'((cp >> 12) & 'h3f));
            str_bytes.push_back(8'h80 | 8'((cp >> 6) & 'h3f));
            str_bytes.push_back(8'h80 | 8'(cp & 'h3f));
         end
      endcase
   endtask

   // Builds the bytes of one random string into str_bytes.
   task automatic build_string_bytes();
      int unsigned kind;
      int unsigned cp;
      int unsigned n;
      int unsigned pos;
      int unsigned boundary[9];
      boundary = '{'h7f, 'h80, 'h7ff, 'h800, 'hd7ff, 'he000, 'hffff, 'h10000, 'h10ffff};
      str_bytes.delete();
      kind = $urandom_range(0, 19);
      if (kind <= 1) begin
         // Raw noise.
         n = $urandom_range(1, 6);
         repeat (n) str_bytes.push_back(8'($urandom_range(0, 255)));
         return;
      end
      n = $urandom_range(1, 5);
      repeat (n) begin
         case ($urandom_range(0, 3))
            0: cp = $urandom_range(1, 'h7f);
            1: cp = $urandom_range('h80, 'h7ff);
            2: begin
               cp = $urandom_range('h800, 'hffff);
               if (cp >= 'hd800 && cp <= 'hdfff) cp = cp - 'h800;
            end
            default: cp = $urandom_range('h10000, 'h10ffff);
         endcase
         append_seq(cp, natural_len(cp));
      end
      case (kind)
         2: str_bytes[$urandom_range(0, str_bytes.size() - 1)] = 8'($urandom_range(0, 255));
         3: if (str_bytes.size() > 1) void'(str_bytes.pop_back());
         4, 5: begin
            // Append a character from the edges of the encoding rules.
            case ($urandom_range(0, 5))
               0: append_seq($urandom_range(0, 'h7f), 2);
               1: append_seq($urandom_range(0, 'h7ff), 3);
               2: append_seq($urandom_range(0, 'hffff), 4);
               3: append_seq($urandom_range('hd800, 'hdfff), 3);
               4: append_seq($urandom_range('h110000, 'h1fffff), 4);
               default: begin
                  cp = boundary[$urandom_range(0, 8)];
                  append_seq(cp, natural_len(cp));
               end
            endcase
         end
         6: begin
            pos = $urandom_range(0, str_bytes.size());
            str_bytes.insert(pos, BYTE_NUL);
         end
         default: ;
      endcase
   endtask

   // Random strings, mostly well-formed, with byteless beats and empty terminators.
   task automatic build_random_strings();
      bit empty_term;
      int unsigned i;
      pend_drain = 1'b1;
      while (random_items < RANDOM_BEATS) begin
         strings_built++;
         cur_idling = random_items < QUIET_TAIL_AT && random_items >= quiet_until &&
                      (strings_built / 16) % 3 != 2;
         if (holdoffs_asked == 0 && !pend_holdoff && random_items >= HOLDOFF_AT &&
             quiet_until == 0) begin
            // Long receiver stall while the sender keeps offering at full rate.
            pend_holdoff = 1'b1;
            quiet_until = random_items + 200;
            cur_idling = 1'b0;
         end
         if (random_items >= DRAIN_AT && random_items < DRAIN_AT + 20) pend_drain = 1'b1;
         if ($urandom_range(0, 29) == 0) begin
            add_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, 1'b0);
            random_items++;
         end else begin
            build_string_bytes();
            empty_term = $urandom_range(0, 19) == 0;
            for (i = 0; i < str_bytes.size(); i++) begin
               if ($urandom_range(0, 9) == 0) begin
                  add_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, 1'b0);
                  random_items++;
               end
               add_beat(str_bytes[i], 1'b1, i == str_bytes.size() - 1 && !empty_term,
                        1'b0, 1'b0);
               random_items++;
            end
            if (empty_term) begin
               add_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, 1'b0);
               random_items++;
            end
         end
      end
   endtask

   // Cycle counter and run limit.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Run limit of %0d cycles reached.", CYCLE_LIMIT);
         $display("simulation failed");
         $finish;
      end
   end

   // Scoreboard: check result beats, then predict from accepted input beats.
   always @(posedge clock) begin : scoreboard
      bit       has_verdict;
      bit       verdict;
      beat_type beat;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_verdicts.size() == 0) begin
               note_failure("result with none expected", 1'bx, rsp_string_valid);
            end else begin
               verdict = expected_verdicts.pop_front();
               if (rsp_string_valid !== verdict) begin
                  note_failure("string_valid", verdict, rsp_string_valid);
               end
               verdicts_checked++;
               if (verdict) valid_verdicts++;
            end
         end
         if (req_valid && req_ready) begin
            beat = byte_beats[accept_idx];
            accept_idx++;
            step_utf8_tracker(req_byte_value, req_byte_present, req_last_byte,
                              has_verdict, verdict);
            if (has_verdict) expected_verdicts.push_back(beat.typed ? beat.typed_verdict
                                                                    : verdict);
         end
      end
   end

   // Result side: random stalls, and the long hold-off when the sender asks.
   initial begin
      rsp_ready = 1'b1;
      forever begin
         @(negedge clock);
         if (holdoffs_done != holdoffs_asked) begin
            holdoffs_done++;
            rsp_ready <= 1'b0;
            repeat (HOLDOFF_CYCLES) @(negedge clock);
         end else if (rsp_idling && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   // Stimulus: directed table, then random strings, driven at the falling edge.
   initial begin : sender
      int unsigned i;
      int unsigned gap;
      reset = 1'b1;
      req_valid = 1'b0;
      req_byte_value = '0;
      req_byte_present = 1'b0;
      req_last_byte = 1'b0;
      rsp_idling = 1'b0;
      trk_cont_left = LEN_NONE;
      trk_seq_len = LEN_NONE;
      trk_acc = '0;
      trk_error = 1'b0;

      cur_idling = 1'b1;
      for (i = 0; i < DIRECTED_ROWS; i++) begin
         add_beat(DIRECTED[i].value, DIRECTED[i].present, DIRECTED[i].last,
                  DIRECTED[i].typed, DIRECTED[i].verdict);
      end
      build_random_strings();

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (i = 0; i < byte_beats.size(); i++) begin
         @(negedge clock);
         rsp_idling = byte_beats[i].idling;
         if (byte_beats[i].drain_first) begin
            // Pause until every verdict so far has come back.
            req_valid <= 1'b0;
            do @(negedge clock); while (expected_verdicts.size() != 0);
         end
         if (byte_beats[i].rx_holdoff) holdoffs_asked++;
         gap = (byte_beats[i].idling && $urandom_range(0, 6) == 0) ? $urandom_range(1, 18) : 0;
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         req_valid <= 1'b1;
         req_byte_value <= byte_beats[i].value;
         req_byte_present <= byte_beats[i].present;
         req_last_byte <= byte_beats[i].last;
         do @(posedge clock); while (!req_ready);
      end
      @(negedge clock);
      req_valid <= 1'b0;

      // Let the last verdicts drain, then wait on for stray results.
      while (expected_verdicts.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      $display("Sent %0d beats in %0d random strings plus the directed table.",
               accept_idx, strings_built);
      $display("Checked %0d verdicts, %0d of them valid strings, in %0d cycles.",
               verdicts_checked, valid_verdicts, cycle_count);
      if (failures == 0) begin
         $display("simulation ok");
      end else begin
         $display("%0d failures.", failures);
         $display("simulation failed");
      end
      $finish;
   end

endmodule
